>>> rtl/lbq_pkg.sv
// shared types and constants for the line billboard quad expander
package lbq_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 32;
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int CROSS_W         = PROD_W + 2;
    localparam int MAG_W           = PROD_W + 1;
    localparam int SM_W            = 30;
    localparam int SQ_W            = 2 * SM_W + 2;
    localparam int LEN_W           = SM_W + 1;
    localparam int REM_W           = LEN_W + COORD_FRAC_BITS;
    localparam int HALF_W          = COORD_FRAC_BITS + 1;
    localparam int SQRT_STEPS      = SQ_W / 2;
    localparam int CNT_W           = $clog2(SQRT_STEPS + 1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [HALF_W-1:0]  half_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic signed [COORD_W-1:0] camera_z;
        logic [31:0]               start_color;
        logic [31:0]               end_color;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic [31:0]               vertex_color;
        logic [1:0]                corner;
        logic                      last;
        logic                      degenerate;
    } out_item_t;

    typedef struct packed {
        coord_t [2:0] pt_s;
        coord_t [2:0] pt_e;
        diff_t [2:0]  dir;
        diff_t [2:0]  us;
        diff_t [2:0]  ue;
        logic [31:0]  color_s;
        logic [31:0]  color_e;
    } line_job_t;

    typedef struct packed {
        coord_t [2:0] pt_s;
        coord_t [2:0] pt_e;
        half_t [2:0]  h_s;
        half_t [2:0]  h_e;
        logic         dg_s;
        logic         dg_e;
        logic [31:0]  color_s;
        logic [31:0]  color_e;
    } quad_job_t;

endpackage

>>> rtl/line_billboard_quad_expander.sv
// top level of the line billboard quad expander
//
// Each accepted line beat yields four corner beats, start+n, start-n, end-m, end+m,
// where n and m are half-unit normals of cross(camera - point, end - start).
// Lines are taken into an input register and a two-entry queue, so up to three
// lines can be accepted ahead of the engine. The normal engine works on one line
// at a time, one end after the other. Per end it forms the cross product on the
// single shared 33x33 multiplier, takes the signs and magnitudes, normalizes,
// sums the squares on the same multiplier, takes a one-bit-a-cycle square root
// and runs a one-bit-a-cycle division to 16 fraction bits for each of the three
// components, then moves to the end point or, after it, hands the quad over. An
// end with a zero cross product skips the normalize, square, square root and
// division steps. Corner emission of the previous line overlaps the next line's
// work.
// A zero cross product gives a zero normal and sets degenerate on that end's corners.
module line_billboard_quad_expander (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lbq_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lbq_pkg::out_item_t m_data
);
    import lbq_pkg::*;

    logic      front_valid, front_ready;
    line_job_t front_data;
    logic      fifo_valid, fifo_ready;
    line_job_t fifo_data;
    logic      quad_valid, quad_ready;
    quad_job_t quad_data;

    lbq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job_data  (front_data)
    );

    lbq_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data),
        .pop_valid  (fifo_valid),
        .pop_ready  (fifo_ready),
        .pop_data   (fifo_data)
    );

    lbq_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (fifo_valid),
        .job_ready  (fifo_ready),
        .job_data   (fifo_data),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad_data  (quad_data)
    );

    lbq_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .quad_valid (quad_valid),
        .quad_ready (quad_ready),
        .quad_data  (quad_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> rtl/lbq_front.sv
// input stage: registers a line beat and forms the difference vectors
module lbq_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lbq_pkg::in_item_t  s_data,
    output logic               job_valid,
    input  logic               job_ready,
    output lbq_pkg::line_job_t job_data
);
    import lbq_pkg::*;

    in_item_t item_reg, item_next;
    logic     valid_reg, valid_next;

    assign s_ready   = !valid_reg || job_ready;
    assign job_valid = valid_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            item_next  = s_data;
        end else if (job_ready) begin
            valid_next = 1'b0;
        end
    end

    always_comb begin
        job_data.pt_s[0] = item_reg.start_x;
        job_data.pt_s[1] = item_reg.start_y;
        job_data.pt_s[2] = item_reg.start_z;
        job_data.pt_e[0] = item_reg.end_x;
        job_data.pt_e[1] = item_reg.end_y;
        job_data.pt_e[2] = item_reg.end_z;
        job_data.dir[0]  = DIFF_W'(item_reg.end_x) - DIFF_W'(item_reg.start_x);
        job_data.dir[1]  = DIFF_W'(item_reg.end_y) - DIFF_W'(item_reg.start_y);
        job_data.dir[2]  = DIFF_W'(item_reg.end_z) - DIFF_W'(item_reg.start_z);
        job_data.us[0]   = DIFF_W'(item_reg.camera_x) - DIFF_W'(item_reg.start_x);
        job_data.us[1]   = DIFF_W'(item_reg.camera_y) - DIFF_W'(item_reg.start_y);
        job_data.us[2]   = DIFF_W'(item_reg.camera_z) - DIFF_W'(item_reg.start_z);
        job_data.ue[0]   = DIFF_W'(item_reg.camera_x) - DIFF_W'(item_reg.end_x);
        job_data.ue[1]   = DIFF_W'(item_reg.camera_y) - DIFF_W'(item_reg.end_y);
        job_data.ue[2]   = DIFF_W'(item_reg.camera_z) - DIFF_W'(item_reg.end_z);
        job_data.color_s = item_reg.start_color;
        job_data.color_e = item_reg.end_color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

>>> rtl/lbq_fifo.sv
// two-entry queue of line jobs between the front and the normal engine
module lbq_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  lbq_pkg::line_job_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output lbq_pkg::line_job_t pop_data
);
    import lbq_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    line_job_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != (PTR_W + 1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/lbq_engine.sv
// normal engine: cross product, normalize, square root and divide per line end
module lbq_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  lbq_pkg::line_job_t job_data,
    output logic               quad_valid,
    input  logic               quad_ready,
    output lbq_pkg::quad_job_t quad_data
);
    import lbq_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE, E_MUL, E_ABS, E_NORM, E_SQ, E_SQRT, E_DLOAD, E_DIV, E_NEXT, E_DONE
    } state_t;

    state_t             state_reg, state_next;
    line_job_t          job_reg, job_next;
    logic               end_reg, end_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         comp_reg, comp_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [2:0][CROSS_W-1:0]  acc_reg, acc_next;
    logic [2:0]         neg_reg, neg_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [SQ_W-1:0]    res_reg, res_next;
    logic [SQ_W-1:0]    bit_reg, bit_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   dsh_reg, dsh_next;
    logic [COORD_FRAC_BITS-1:0] q_reg, q_next;
    half_t [2:0]        hs_reg, hs_next;
    half_t [2:0]        he_reg, he_next;
    logic               dgs_reg, dgs_next;
    logic               dge_reg, dge_next;

    diff_t               mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    diff_t [2:0]         u_sel;
    logic [2:0]          step_j;
    logic [CROSS_W-1:0]  prod_ext;
    logic [MAG_W-1:0]    mag_or;
    logic [SM_W-1:0]     sm_cur;
    logic [SQ_W-1:0]     trial;
    logic                qbit;
    logic [COORD_FRAC_BITS-1:0] q_fin;
    half_t               h_fin;

    assign mul_p     = mul_a * mul_b;
    assign u_sel     = end_reg ? job_reg.ue : job_reg.us;
    assign step_j    = cnt_reg[2:0] - 3'd1;
    assign prod_ext  = CROSS_W'(prod_reg);
    assign mag_or    = acc_reg[0][MAG_W-1:0] | acc_reg[1][MAG_W-1:0]
                     | acc_reg[2][MAG_W-1:0];
    assign trial     = res_reg + bit_reg;
    assign qbit      = rem_reg >= dsh_reg;
    assign q_fin     = {q_reg[COORD_FRAC_BITS-2:0], qbit};
    assign h_fin     = neg_reg[comp_reg] ? -HALF_W'(q_fin) : HALF_W'(q_fin);
    assign job_ready  = state_reg == E_IDLE;
    assign quad_valid = state_reg == E_DONE;

    always_comb begin
        unique case (state_reg)
            E_DLOAD: sm_cur = acc_reg[comp_reg][MAG_W-1 -: SM_W];
            default: sm_cur = acc_reg[cnt_reg[1:0]][MAG_W-1 -: SM_W];
        endcase
    end

    always_comb begin
        quad_data.pt_s    = job_reg.pt_s;
        quad_data.pt_e    = job_reg.pt_e;
        quad_data.h_s     = hs_reg;
        quad_data.h_e     = he_reg;
        quad_data.dg_s    = dgs_reg;
        quad_data.dg_e    = dge_reg;
        quad_data.color_s = job_reg.color_s;
        quad_data.color_e = job_reg.color_e;
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        end_next   = end_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        prod_next  = mul_p;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sq_next    = sq_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        hs_next    = hs_reg;
        he_next    = he_reg;
        dgs_next   = dgs_reg;
        dge_next   = dge_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            E_IDLE: begin
                if (job_valid) begin
                    job_next   = job_data;
                    end_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = E_MUL;
                end
            end
            E_MUL: begin
                unique case (cnt_reg[2:0])
                    3'd0: begin mul_a = u_sel[1]; mul_b = job_reg.dir[2]; end
                    3'd1: begin mul_a = u_sel[2]; mul_b = job_reg.dir[1]; end
                    3'd2: begin mul_a = u_sel[2]; mul_b = job_reg.dir[0]; end
                    3'd3: begin mul_a = u_sel[0]; mul_b = job_reg.dir[2]; end
                    3'd4: begin mul_a = u_sel[0]; mul_b = job_reg.dir[1]; end
                    3'd5: begin mul_a = u_sel[1]; mul_b = job_reg.dir[0]; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (cnt_reg != '0) begin
                    if (step_j[0]) begin
                        acc_next[step_j[2:1]] = acc_reg[step_j[2:1]] - prod_ext;
                    end else begin
                        acc_next[step_j[2:1]] = prod_ext;
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(6)) begin
                    state_next = E_ABS;
                end
            end
            E_ABS: begin
                for (int i = 0; i < 3; i++) begin
                    neg_next[i] = acc_reg[i][CROSS_W-1];
                    acc_next[i] = acc_reg[i][CROSS_W-1] ? -acc_reg[i] : acc_reg[i];
                end
                if (acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0) begin
                    if (end_reg) begin
                        he_next  = '0;
                        dge_next = 1'b1;
                    end else begin
                        hs_next  = '0;
                        dgs_next = 1'b1;
                    end
                    state_next = E_NEXT;
                end else begin
                    if (end_reg) begin
                        dge_next = 1'b0;
                    end else begin
                        dgs_next = 1'b0;
                    end
                    state_next = E_NORM;
                end
            end
            E_NORM: begin
                if (mag_or[MAG_W-1 -: 8] == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        acc_next[i] = acc_reg[i] << 8;
                    end
                end else if (!mag_or[MAG_W-1]) begin
                    for (int i = 0; i < 3; i++) begin
                        acc_next[i] = acc_reg[i] << 1;
                    end
                end else begin
                    cnt_next   = '0;
                    state_next = E_SQ;
                end
            end
            E_SQ: begin
                mul_a = DIFF_W'(sm_cur);
                mul_b = DIFF_W'(sm_cur);
                if (cnt_reg == '0) begin
                    sq_next = '0;
                end else begin
                    sq_next = sq_reg + prod_reg[SQ_W-1:0];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(3)) begin
                    cnt_next   = '0;
                    res_next   = '0;
                    bit_next   = SQ_W'(1) << (SQ_W - 2);
                    state_next = E_SQRT;
                end
            end
            E_SQRT: begin
                if (sq_reg >= trial) begin
                    sq_next  = sq_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    comp_next  = '0;
                    state_next = E_DLOAD;
                end
            end
            E_DLOAD: begin
                rem_next   = REM_W'({sm_cur, {COORD_FRAC_BITS{1'b0}}})
                           + REM_W'(res_reg[LEN_W-1:0]);
                dsh_next   = {res_reg[LEN_W-1:0], {COORD_FRAC_BITS{1'b0}}};
                q_next     = '0;
                cnt_next   = '0;
                state_next = E_DIV;
            end
            E_DIV: begin
                if (qbit) begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = q_fin;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COORD_FRAC_BITS - 1)) begin
                    if (end_reg) begin
                        he_next[comp_reg] = h_fin;
                    end else begin
                        hs_next[comp_reg] = h_fin;
                    end
                    if (comp_reg == 2'd2) begin
                        state_next = E_NEXT;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = E_DLOAD;
                    end
                end
            end
            E_NEXT: begin
                if (!end_reg) begin
                    end_next   = 1'b1;
                    cnt_next   = '0;
                    state_next = E_MUL;
                end else begin
                    state_next = E_DONE;
                end
            end
            E_DONE: begin
                if (quad_ready) begin
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            state_reg <= state_next;
        end
        job_reg  <= job_next;
        end_reg  <= end_next;
        cnt_reg  <= cnt_next;
        comp_reg <= comp_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        hs_reg   <= hs_next;
        he_reg   <= he_next;
        dgs_reg  <= dgs_next;
        dge_reg  <= dge_next;
    end

endmodule

>>> rtl/lbq_emit.sv
// corner emitter: four saturated corners per quad through an output register
module lbq_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               quad_valid,
    output logic               quad_ready,
    input  lbq_pkg::quad_job_t quad_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lbq_pkg::out_item_t m_data
);
    import lbq_pkg::*;

    function automatic coord_t sat_corner(coord_t p, half_t h, logic plus);
        logic signed [COORD_W+1:0] s;
        s = plus ? ((COORD_W + 2)'(p) + (COORD_W + 2)'(h))
                 : ((COORD_W + 2)'(p) - (COORD_W + 2)'(h));
        if (s[COORD_W+1:COORD_W-1] == '0 || s[COORD_W+1:COORD_W-1] == '1) begin
            return s[COORD_W-1:0];
        end else if (s[COORD_W+1]) begin
            return {1'b1, {(COORD_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W - 1){1'b1}}};
        end
    endfunction

    logic      busy_reg, busy_next;
    quad_job_t quad_reg, quad_next;
    logic [1:0] k_reg, k_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    logic        advance, use_end, plus;
    coord_t [2:0] pt;
    half_t [2:0]  h;
    out_item_t   corner_item;

    assign quad_ready = !busy_reg;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign advance    = busy_reg && (!m_valid_reg || m_ready);
    assign use_end    = k_reg[1];
    assign plus       = k_reg == 2'd0 || k_reg == 2'd3;
    assign pt         = use_end ? quad_reg.pt_e : quad_reg.pt_s;
    assign h          = use_end ? quad_reg.h_e : quad_reg.h_s;

    always_comb begin
        corner_item.vertex_x     = sat_corner(pt[0], h[0], plus);
        corner_item.vertex_y     = sat_corner(pt[1], h[1], plus);
        corner_item.vertex_z     = sat_corner(pt[2], h[2], plus);
        corner_item.vertex_color = use_end ? quad_reg.color_e : quad_reg.color_s;
        corner_item.corner       = k_reg;
        corner_item.last         = k_reg == 2'd3;
        corner_item.degenerate   = use_end ? quad_reg.dg_e : quad_reg.dg_s;
    end

    always_comb begin
        busy_next    = busy_reg;
        quad_next    = quad_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = corner_item;
            k_next       = k_reg + 1'b1;
            if (k_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (!busy_reg && quad_valid) begin
            busy_next = 1'b1;
            quad_next = quad_data;
            k_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            k_reg       <= k_next;
        end
        quad_reg   <= quad_next;
        m_data_reg <= m_data_next;
    end

endmodule
